FILE: sv/sv39ptw_pkg.sv
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// shared constants, codes and control types of the sv39 page table walker
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

  localparam int DEF_TABLE_PAGES   = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int PPN_W             = 44;
  localparam int PTE_W             = 54;
  localparam int VA_W              = 39;
  localparam int PA_W              = 56;
  localparam int PAGE_OFS_W        = 12;
  localparam int ENTRY_IDX_W       = 13;
  localparam int CFG_IDX_W         = 1;

  // pte flag bits
  localparam int FLAG_V_BIT = 0;
  localparam int FLAG_U_BIT = 4;
  localparam int PTE_PPN_LO = 10;

  // item kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_PPN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_BASE = 1'b1;

  // walk levels
  localparam logic [1:0] LVL_TOP  = 2'd2;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_UNMAPPED  = 3'd2,
    ST_NOT_USER  = 3'd3,
    ST_OUTSIDE   = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic start;     // beat accepted this cycle
    logic step;      // follow the pointer entry to the next level
    logic load_out;  // move the walk result into the output register
    logic clear_en;  // write one zero word of the clearing pass
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic out_free;
    logic clear_last;
  } dp_status_t;

endpackage

FILE: sv/sv39_page_table_walker.sv
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// three-level sv39 translation over a local page-table store
// ----------------------------------------------------------------------------
// Each input beat is either a table write (tuser 0) or a translation
// (tuser 1). A write stores one 54-bit entry at a word of the local store
// (words beyond the store are dropped) and returns address 0, status ok.
// A translation walks the root, middle and leaf tables using address bits
// 38..30, 29..21 and 20..12 and returns the page-aligned physical address
// or a status: 1 out of range (bit 38 set), 2 not mapped (entry without V),
// 3 not user (leaf without U), 4 table outside store. Tables are found in
// the store at page (ppn - store_base_ppn) mod 2^44; upper-level entries
// with V are always followed as pointers. Every item gives one result beat.
// A translation makes up to three dependent reads of the table ram, each
// with a registered read; the next item can be accepted once the result has
// entered the output register, while that beat may still wait. After reset
// the store is zeroed by a clearing pass over all TABLE_PAGES * 512 words,
// during which no item is accepted; config writes are always taken.
// ----------------------------------------------------------------------------
module sv39_page_table_walker
  import sv39ptw_pkg::*;
#(
  parameter int TABLE_PAGES = DEF_TABLE_PAGES
) (
  input  logic                 clk,
  input  logic                 rst,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PPN_W-1:0]     cfg_data,
  // input beats
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [111:0]         s_tdata,  // entry_index[12:0], entry_value[66:13],
                                         // virt_addr[105:67], zero pad above
  input  logic                 s_tuser,  // cmd
  // result beats
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata   // phys_page_addr[55:0], status[58:56],
                                         // zero pad above
);

  ctrl_cmd_t       cmd;
  dp_status_t      sts;
  logic [PA_W-1:0] phys_page_addr;
  status_t         status;

  // config registers live in the datapath and never stall
  assign cfg_ready = 1'b1;

  sv39ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sv39ptw_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (s_tuser),
    .entry_index    (s_tdata[12:0]),
    .entry_value    (s_tdata[66:13]),
    .virt_addr      (s_tdata[105:67]),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .phys_page_addr (phys_page_addr),
    .status         (status)
  );

  // pack the result beat
  assign m_tdata = {5'b0, status, phys_page_addr};

endmodule

FILE: sv/sv39ptw_ram.sv
// ----------------------------------------------------------------------------
// sv39ptw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sv39ptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/sv39ptw_ctrl.sv
// ----------------------------------------------------------------------------
// sv39ptw_ctrl
// sequencer: clearing pass, idle, and the level by level walk
// ----------------------------------------------------------------------------
module sv39ptw_ctrl
  import sv39ptw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_WALK  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (!sts.walk_done) begin
          cmd.step = 1'b1;
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // a result only lands in a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an unread beat");

  // after a result the walker is ready again
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (state == S_IDLE))
    else $error("walker not idle after result");

  // a pointer step keeps the walk going
  a_step_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (state == S_WALK))
    else $error("walk left after a pointer step");

endmodule

FILE: sv/sv39ptw_dp.sv
// ----------------------------------------------------------------------------
// sv39ptw_dp
// walk datapath: config registers, table ram, address forming, result register
// ----------------------------------------------------------------------------
module sv39ptw_dp
  import sv39ptw_pkg::*;
#(
  parameter int TABLE_PAGES = DEF_TABLE_PAGES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             sts,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PPN_W-1:0]       cfg_data,
  input  logic                   in_cmd,
  input  logic [ENTRY_IDX_W-1:0] entry_index,
  input  logic [PTE_W-1:0]       entry_value,
  input  logic [VA_W-1:0]        virt_addr,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [PA_W-1:0]        phys_page_addr,
  output status_t                status
);

  localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int PAGE_W      = $clog2(TABLE_PAGES);
  localparam int ADDR_W      = PAGE_W + IDX_W;

  logic [PPN_W-1:0]  root_ppn;
  logic [PPN_W-1:0]  store_base;
  logic [VA_W-1:0]   va_r;
  logic [1:0]        lvl;
  logic              is_wr;
  logic              range_bad;
  logic              outside;
  logic [ADDR_W-1:0] clr_cnt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PTE_W-1:0]  ram_wdata, ram_q;

  logic [PPN_W-1:0]  rd_ppn, rd_page;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_ok;
  logic              wr_in_store;

  status_t           res_status;
  logic [PA_W-1:0]   res_addr;
  logic              walk_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_ppn   <= '0;
      store_base <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROOT_PPN:   root_ppn   <= cfg_data;
        REG_STORE_BASE: store_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // next table: root on a new item, else the ppn of the entry just read
  assign rd_ppn  = cmd.start ? root_ppn : ram_q[PTE_W-1:PTE_PPN_LO];
  assign rd_page = rd_ppn - store_base;
  assign rd_ok   = (rd_page < PPN_W'(TABLE_PAGES));

  always_comb begin
    if (cmd.start) begin
      rd_idx = virt_addr[38:30];
    end else if (lvl == LVL_TOP) begin
      rd_idx = va_r[29:21];
    end else begin
      rd_idx = va_r[20:12];
    end
  end

  assign ram_raddr = {rd_page[PAGE_W-1:0], rd_idx};
  assign ram_re    = rd_ok && ((cmd.start && (in_cmd == CMD_XLATE) && !virt_addr[VA_W-1])
                               || cmd.step);

  assign wr_in_store = ({19'b0, entry_index} < 32'(STORE_WORDS));
  assign ram_we      = cmd.clear_en || (cmd.start && (in_cmd == CMD_WRITE) && wr_in_store);
  assign ram_waddr   = cmd.clear_en ? clr_cnt : ADDR_W'(entry_index);
  assign ram_wdata   = cmd.clear_en ? '0 : entry_value;

  sv39ptw_ram #(
    .WIDTH (PTE_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // per item walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl       <= LVL_TOP;
      is_wr     <= 1'b0;
      range_bad <= 1'b0;
      outside   <= 1'b0;
      clr_cnt   <= '0;
    end else begin
      if (cmd.start) begin
        lvl       <= LVL_TOP;
        is_wr     <= (in_cmd == CMD_WRITE);
        range_bad <= virt_addr[VA_W-1];
        outside   <= !rd_ok;
      end else if (cmd.step) begin
        lvl     <= lvl - 2'd1;
        outside <= !rd_ok;
      end
      if (cmd.clear_en) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      va_r <= virt_addr;
    end
  end

  // check the entry read at the current level
  always_comb begin
    res_status = ST_OK;
    res_addr   = '0;
    walk_done  = 1'b1;
    if (is_wr) begin
      res_status = ST_OK;
    end else if (range_bad) begin
      res_status = ST_RANGE;
    end else if (outside) begin
      res_status = ST_OUTSIDE;
    end else if (!ram_q[FLAG_V_BIT]) begin
      res_status = ST_UNMAPPED;
    end else if (lvl != LVL_LEAF) begin
      walk_done = 1'b0;
    end else if (!ram_q[FLAG_U_BIT]) begin
      res_status = ST_NOT_USER;
    end else begin
      res_addr = {ram_q[PTE_W-1:PTE_PPN_LO], {PAGE_OFS_W{1'b0}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      phys_page_addr <= res_addr;
      status         <= res_status;
    end
  end

  assign sts.walk_done  = walk_done;
  assign sts.out_free   = !m_tvalid || m_tready;
  assign sts.clear_last = (clr_cnt == ADDR_W'(STORE_WORDS - 1));

  // the leaf level never asks for another table
  a_no_step_at_leaf: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (lvl != LVL_LEAF))
    else $error("pointer step past the leaf level");

  // the single ram port pair is never asked to read and write together
  a_ram_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("table ram read and written in one cycle");

endmodule
